>>> hw/rtl/calcdt_pkg.sv
package calcdt_pkg;

    // Widths of the item fields.
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned MINYR_W  = 12;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned RTCYR_W  = 7;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 16;

    // Calendar limits.
    localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd2099;
    localparam logic [YEAR_W-1:0]  YEAR_BASE      = 14'd2000;
    localparam logic [MINYR_W-1:0] MIN_YEAR_RESET = 12'd2026;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR      = 4'd3;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS  = 5'd29;
    localparam logic [HOUR_W-1:0]  HOUR_MAX       = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX    = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX    = 6'd59;

    // Division by 100 through a reciprocal: q = (y * 5243) >> 19 is exact for
    // every 14-bit year, and the fraction bits stay below 5243 exactly when
    // the year is a multiple of 100.
    localparam int unsigned        RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int unsigned        RECIP_SHIFT = 19;
    localparam int unsigned        PROD_W      = YEAR_W + RECIP_W;

    // Weekday arithmetic over the years 1999..2099: with u = yy - 1996 the
    // Sakamoto year sum is 2480 + u + u/4, and 2480 mod 7 is 2.
    localparam logic [YEAR_W-1:0] WDAY_YEAR_BASE = 14'd1996;
    localparam logic [7:0]        WDAY_BIAS      = 8'd2;
    localparam logic [2:0]        SEVEN          = 3'd7;

    typedef logic [DAY_W-1:0] mdays_arr_t [0:15];
    typedef logic [2:0]       sak_arr_t   [0:15];

    // Days of each month, indexed by month number; codes outside 1..12 read 0.
    localparam mdays_arr_t MONTH_DAYS = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // Sakamoto month offsets, indexed by month number.
    localparam sak_arr_t SAK_OFFSET = '{
        3'd0, 3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5,
        3'd1, 3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0
    };

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } date_t;

    typedef struct packed {
        logic [RTCYR_W-1:0] rtc_year;
        logic [WDAY_W-1:0]  weekday;
        logic [DAY_W-1:0]   month_length;
        logic               valid_res;
    } result_t;

endpackage

>>> hw/rtl/calendar_datetime_checker.sv
// Channel   Direction  Item                                    Handshake
// s_axis    in         year, month, day, hour, minute, second  tvalid / tready
// m_axis    out        valid_res, month_length, weekday,       tvalid / tready
//                      rtc_year
// cfg       in         min_year                                cfg_wr_en, no wait
//
// One item per cycle is sustained while m_axis takes each result. An item is
// registered in the input register, and its result then in the result register,
// from which m_axis presents it. All the checks, the one 14x13 reciprocal
// multiply and the weekday sum sit in between.
// Reset (rst_n low, asynchronous) empties both stages and loads min_year with 2026.
// When the result register is full and not taken, the whole pipeline holds and
// s_axis_tready drops only if the input register is full as well.
module calendar_datetime_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year [13:0], month [17:14], day [22:18], hour [27:23], minute [33:28],
    // second [39:34]
    input  logic [39:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // valid_res [0], month_length [5:1], weekday [8:6], rtc_year [15:9]
    output logic [15:0] m_axis_tdata,

    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);

    // Configuration register: earliest year accepted as valid.
    logic [calcdt_pkg::MINYR_W-1:0] min_year_reg;

    // Input stage.
    logic               in_valid_reg;
    calcdt_pkg::date_t  in_reg;

    // Result stage.
    logic                out_valid_reg;
    calcdt_pkg::result_t out_reg;
    calcdt_pkg::result_t out_next;

    logic advance;

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= calcdt_pkg::MIN_YEAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_year_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= calcdt_pkg::date_t'(s_axis_tdata);
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Check logic between the two registers.
    // ------------------------------------------------------------------
    logic [calcdt_pkg::YEAR_W-1:0]  year_lo;
    logic [calcdt_pkg::PROD_W-1:0]  recip_prod;
    logic [calcdt_pkg::PROD_W-calcdt_pkg::RECIP_SHIFT-1:0] century;
    logic                           div100;
    logic                           leap;
    logic [calcdt_pkg::DAY_W-1:0]   month_len;
    logic                           ok;
    logic                           early;
    logic [calcdt_pkg::YEAR_W-1:0]  year_off;
    logic [6:0]                     u;
    logic [7:0]                     wsum;
    logic [4:0]                     fold1;
    logic [3:0]                     fold2;
    logic [calcdt_pkg::WDAY_W-1:0]  wday;
    logic [calcdt_pkg::YEAR_W-1:0]  rtc_full;

    always_comb
    begin
        // A minimum below 2000 acts as 2000.
        if (calcdt_pkg::YEAR_W'(min_year_reg) < calcdt_pkg::YEAR_BASE)
        begin
            year_lo = calcdt_pkg::YEAR_BASE;
        end
        else
        begin
            year_lo = calcdt_pkg::YEAR_W'(min_year_reg);
        end

        // Gregorian leap rule over the full 14-bit year.
        recip_prod = in_reg.year * calcdt_pkg::RECIP_100;
        century    = recip_prod[calcdt_pkg::PROD_W-1:calcdt_pkg::RECIP_SHIFT];
        div100     = recip_prod[calcdt_pkg::RECIP_SHIFT-1:0]
                     < calcdt_pkg::RECIP_SHIFT'(calcdt_pkg::RECIP_100);
        leap       = (in_reg.year[1:0] == 2'b00 && !div100)
                     || (div100 && century[1:0] == 2'b00);

        if (in_reg.month == calcdt_pkg::MONTH_FEB && leap)
        begin
            month_len = calcdt_pkg::FEB_LEAP_DAYS;
        end
        else
        begin
            month_len = calcdt_pkg::MONTH_DAYS[in_reg.month];
        end

        // An illegal month gives a zero length, so the day check rejects it too.
        ok = (in_reg.year >= year_lo) && (in_reg.year <= calcdt_pkg::YEAR_MAX)
             && (in_reg.month inside {[4'd1:4'd12]})
             && (in_reg.day != '0) && (in_reg.day <= month_len)
             && (in_reg.hour <= calcdt_pkg::HOUR_MAX)
             && (in_reg.minute <= calcdt_pkg::MINUTE_MAX)
             && (in_reg.second <= calcdt_pkg::SECOND_MAX);

        // Weekday, only meaningful for years 2000..2099 (yy down to 1999).
        early    = in_reg.month < calcdt_pkg::MONTH_MAR;
        year_off = in_reg.year - calcdt_pkg::WDAY_YEAR_BASE
                   - calcdt_pkg::YEAR_W'(early);
        u        = year_off[6:0];
        wsum     = calcdt_pkg::WDAY_BIAS + 8'(u) + 8'(u[6:2])
                   + 8'(calcdt_pkg::SAK_OFFSET[in_reg.month]) + 8'(in_reg.day);

        // Mod 7 by folding octal digits, since 8 is 1 mod 7.
        fold1 = 5'(wsum[2:0]) + 5'(wsum[5:3]) + 5'(wsum[7:6]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
        if (fold2 >= 4'(calcdt_pkg::SEVEN))
        begin
            wday = 3'(fold2 - 4'(calcdt_pkg::SEVEN));
        end
        else
        begin
            wday = fold2[2:0];
        end

        rtc_full = in_reg.year - calcdt_pkg::YEAR_BASE;

        out_next.valid_res    = ok;
        out_next.month_length = month_len;
        out_next.weekday      = ok ? wday : '0;
        out_next.rtc_year     = ok ? rtc_full[calcdt_pkg::RTCYR_W-1:0] : '0;
    end

endmodule
